/* hw/rtl/vpes_pkg.sv */
package vpes_pkg;

	localparam int NUM_VP_DEF     = 3;
	localparam int NUM_CH_DEF     = 3;
	localparam int COORD_BITS_DEF = 12;
	localparam int VP_CARRIED     = 3;
	localparam int CH_CARRIED     = 3;
	localparam int IDX_W          = 2;
	localparam int ACC_W          = 48;
	localparam int CFG_IDX_W      = 4;
	localparam int DIR_W          = 19;
	localparam int DIV_STEPS      = 46;

	typedef struct packed {
		logic [11:0]        pixel_x;
		logic [11:0]        pixel_y;
		logic signed [15:0] grad_x_ch0;
		logic signed [15:0] grad_x_ch1;
		logic signed [15:0] grad_x_ch2;
		logic signed [15:0] grad_y_ch0;
		logic signed [15:0] grad_y_ch1;
		logic signed [15:0] grad_y_ch2;
		logic [15:0]        mask_ch0;
		logic [15:0]        mask_ch1;
		logic [15:0]        mask_ch2;
		logic               last_pixel;
	} pix_item_t;

	typedef struct packed {
		logic [ACC_W-1:0] score_sum;
	} res_item_t;

	typedef struct packed {
		logic [CFG_IDX_W-1:0] idx;
		logic [31:0]          wdata;
	} cfg_req_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_VP1_X, CFG_VP1_Y, CFG_VP2_X, CFG_VP2_Y,
		CFG_VP3_X, CFG_VP3_Y, CFG_COEF_OFFSET, CFG_COEF_SLOPE
	} cfg_reg_t;

	typedef struct packed {
		logic                    done;
		logic signed [DIR_W-1:0] ux;
		logic signed [DIR_W-1:0] uy;
	} lane_res_t;

	typedef enum logic [1:0] {T_IDLE, T_START, T_LANES, T_MERGE} top_state_t;

	typedef enum logic [2:0] {
		L_IDLE, L_NORM, L_SQX, L_SQY, L_SQRT, L_DIV, L_DONE
	} lane_state_t;

	typedef enum logic [2:0] {
		M_IDLE, M_MUL1, M_MUL2, M_LIN, M_TERM, M_ACC, M_EMIT
	} mrg_state_t;

endpackage

/* hw/rtl/vpes_if.sv */
interface vpes_pix_if;
	logic                  valid;
	logic                  ready;
	vpes_pkg::pix_item_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vpes_res_if;
	logic                  valid;
	logic                  ready;
	vpes_pkg::res_item_t   data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface vpes_cfg_if;
	logic                  valid;
	logic                  ready;
	vpes_pkg::cfg_req_t    data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

/* hw/rtl/vpes_lane.sv */
module vpes_lane (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [31:0]   vp_x,
	input  logic signed [31:0]   vp_y,
	input  logic [11:0]          px,
	input  logic [11:0]          py,
	output vpes_pkg::lane_res_t  res
);
	import vpes_pkg::*;

	lane_state_t state_q, state_d;
	logic [32:0] ax_q, ay_q, ax_c, ay_c, mx;
	logic        nx_q, ny_q;
	logic signed [33:0] dx, dy;
	logic [63:0] v_q, r_q, bit_q, rb;
	logic [31:0] remx_q, remy_q, sdiv;
	logic [32:0] trx, try_c;
	logic [45:0] numx_q, numy_q;
	logic [5:0]  cnt_q;
	logic        zero_c, div_last;

	always_comb begin
		dx     = $signed({{2{vp_x[31]}}, vp_x}) - $signed({10'b0, px, 12'b0});
		dy     = $signed({{2{vp_y[31]}}, vp_y}) - $signed({10'b0, py, 12'b0});
		ax_c   = dx[33] ? 33'(-dx) : 33'(dx);
		ay_c   = dy[33] ? 33'(-dy) : 33'(dy);
		zero_c = (ax_c == '0) && (ay_c == '0);
		mx     = (ax_q > ay_q) ? ax_q : ay_q;
		rb     = r_q + bit_q;
		sdiv   = (r_q[31:0] == '0) ? 32'd1 : r_q[31:0];
		trx    = {remx_q, numx_q[45]};
		try_c  = {remy_q, numy_q[45]};
		div_last = (cnt_q == 6'(DIV_STEPS - 1));
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			L_IDLE, L_DONE: if (start) state_d = zero_c ? L_DONE : L_NORM;
			L_NORM: if (mx < 33'h4000_0000 && mx >= 33'h2000_0000) state_d = L_SQX;
			L_SQX:  state_d = L_SQY;
			L_SQY:  state_d = L_SQRT;
			L_SQRT: if (bit_q == '0) state_d = L_DIV;
			L_DIV:  if (div_last) state_d = L_DONE;
			default: state_d = L_IDLE;
		endcase
	end

	always_comb begin
		res.done = (state_q == L_DONE);
		res.ux   = nx_q ? -DIR_W'($signed({1'b0, numx_q[16:0]}))
		                :  DIR_W'($signed({1'b0, numx_q[16:0]}));
		res.uy   = ny_q ? -DIR_W'($signed({1'b0, numy_q[16:0]}))
		                :  DIR_W'($signed({1'b0, numy_q[16:0]}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= L_IDLE;
		else         state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			L_IDLE, L_DONE: if (start) begin
				ax_q   <= ax_c;
				ay_q   <= ay_c;
				nx_q   <= dx[33];
				ny_q   <= dy[33];
				numx_q <= '0;
				numy_q <= '0;
			end
			L_NORM: begin
				if (mx >= 33'h4000_0000) begin
					ax_q <= ax_q >> 1;
					ay_q <= ay_q >> 1;
				end else if (mx < 33'h2000_0000) begin
					ax_q <= ax_q << 1;
					ay_q <= ay_q << 1;
				end
			end
			L_SQX: v_q <= 64'(ax_q[29:0]) * 64'(ax_q[29:0]);
			L_SQY: begin
				v_q   <= v_q + 64'(ay_q[29:0]) * 64'(ay_q[29:0]);
				r_q   <= '0;
				bit_q <= 64'd1 << 62;
			end
			L_SQRT: begin
				if (bit_q != '0) begin
					if (v_q >= rb) begin
						v_q <= v_q - rb;
						r_q <= (r_q >> 1) + bit_q;
					end else begin
						r_q <= r_q >> 1;
					end
					bit_q <= bit_q >> 2;
				end else begin
					remx_q <= '0;
					remy_q <= '0;
					numx_q <= {ax_q[29:0], 16'b0};
					numy_q <= {ay_q[29:0], 16'b0};
					cnt_q  <= '0;
				end
			end
			L_DIV: begin
				if (trx >= 33'(sdiv)) begin
					remx_q <= 32'(trx - 33'(sdiv));
					numx_q <= {numx_q[44:0], 1'b1};
				end else begin
					remx_q <= trx[31:0];
					numx_q <= {numx_q[44:0], 1'b0};
				end
				if (try_c >= 33'(sdiv)) begin
					remy_q <= 32'(try_c - 33'(sdiv));
					numy_q <= {numy_q[44:0], 1'b1};
				end else begin
					remy_q <= try_c[31:0];
					numy_q <= {numy_q[44:0], 1'b0};
				end
				cnt_q <= cnt_q + 6'd1;
			end
			default: ;
		endcase
	end
endmodule

/* hw/rtl/vpes_merge.sv */
module vpes_merge #(
	parameter int NL = vpes_pkg::VP_CARRIED,
	parameter int NC = vpes_pkg::CH_CARRIED
) (
	input  logic                                         clk,
	input  logic                                         arst_n,
	input  logic                                         start,
	input  vpes_pkg::lane_res_t [vpes_pkg::VP_CARRIED-1:0] dirs,
	input  vpes_pkg::pix_item_t                          item,
	input  logic signed [31:0]                           coef_offset,
	input  logic signed [31:0]                           coef_slope,
	output logic                                         done,
	vpes_res_if.source                                   res
);
	import vpes_pkg::*;

	localparam logic [ACC_W-1:0] ACC_MAX = '1;

	mrg_state_t state_q, state_d;
	logic [IDX_W-1:0] v_q, c_q;
	logic signed [34:0] p1_q;
	logic signed [35:0] dot_q;
	logic signed [53:0] lin_q;
	logic [37:0] term_q;
	logic [ACC_W-1:0] acc_q;
	logic res_valid_q;
	res_item_t res_data_q;

	logic signed [15:0] gx_a [CH_CARRIED];
	logic signed [15:0] gy_a [CH_CARRIED];
	logic [15:0]        mk_a [CH_CARRIED];
	logic signed [15:0] gx, gy;
	logic [15:0] mk;
	logic signed [DIR_W-1:0] ux, uy;
	logic [35:0] absd;
	logic [19:0] ad;
	logic [37:0] sc;
	logic [53:0] prod;
	logic [ACC_W:0] sum;
	logic c_end, v_end, emit_load;

	always_comb begin
		gx_a[0] = item.grad_x_ch0; gx_a[1] = item.grad_x_ch1; gx_a[2] = item.grad_x_ch2;
		gy_a[0] = item.grad_y_ch0; gy_a[1] = item.grad_y_ch1; gy_a[2] = item.grad_y_ch2;
		mk_a[0] = item.mask_ch0;   mk_a[1] = item.mask_ch1;   mk_a[2] = item.mask_ch2;
		gx   = gx_a[c_q];
		gy   = gy_a[c_q];
		mk   = mk_a[c_q];
		ux   = dirs[v_q].ux;
		uy   = dirs[v_q].uy;
		absd = dot_q[35] ? 36'(-dot_q) : 36'(dot_q);
		ad   = absd[35:16];
		sc   = (lin_q <= 0) ? '0 : 38'(lin_q[53:16]);
		prod = 54'(sc) * 54'(mk);
		sum  = {1'b0, acc_q} + (ACC_W+1)'(term_q);
	end

	always_comb begin
		c_end     = (c_q == IDX_W'(NC - 1));
		v_end     = (v_q == IDX_W'(NL - 1));
		emit_load = (state_q == M_EMIT) && (!res_valid_q || res.ready);
		done      = ((state_q == M_ACC) && c_end && v_end && !item.last_pixel) || emit_load;
		res.valid = res_valid_q;
		res.data  = res_data_q;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			M_IDLE: if (start) state_d = M_MUL1;
			M_MUL1: state_d = M_MUL2;
			M_MUL2: state_d = M_LIN;
			M_LIN:  state_d = M_TERM;
			M_TERM: state_d = M_ACC;
			M_ACC: begin
				if (c_end && v_end) state_d = item.last_pixel ? M_EMIT : M_IDLE;
				else                state_d = M_MUL1;
			end
			M_EMIT: if (emit_load) state_d = M_IDLE;
			default: state_d = M_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= M_IDLE;
			v_q         <= '0;
			c_q         <= '0;
			acc_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == M_IDLE && start) begin
				v_q <= '0;
				c_q <= '0;
			end
			if (state_q == M_ACC) begin
				acc_q <= sum[ACC_W] ? ACC_MAX : sum[ACC_W-1:0];
				if (c_end) begin
					c_q <= '0;
					v_q <= v_q + IDX_W'(1);
				end else begin
					c_q <= c_q + IDX_W'(1);
				end
			end
			if (emit_load) begin
				res_valid_q <= 1'b1;
				acc_q       <= '0;
			end else if (res.valid && res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == M_MUL1) p1_q <= ux * gx;
		if (state_q == M_MUL2) dot_q <= 36'(p1_q) + uy * gy;
		if (state_q == M_LIN)
			lin_q <= $signed({{6{coef_offset[31]}}, coef_offset, 16'b0})
			       + coef_slope * $signed({1'b0, ad});
		if (state_q == M_TERM) term_q <= prod[53:16];
		if (emit_load) res_data_q.score_sum <= acc_q;
	end
endmodule

/* hw/rtl/vanishing_point_edge_score_top.sv */
// Vanishing point edge score.
// Channel pix (sink) takes one pixel request: coordinates, x/y gradients and
// mask weights of three channels, and a last-pixel flag. Channel res (source)
// returns the accumulated 48-bit score, once per image, on the last pixel.
// Channel cfg (sink) writes the vanishing points and score coefficients;
// it is always ready; it is to be written only while the block is idle, which the block itself does not enforce.
// Each vanishing point has its own lane that forms the unit direction:
// a normalizing shift, squaring of x and then of y, a 32-step square root
// and a 46-step divider. The merge stage then runs the multiply, dot
// product, linear score, mask weighting and accumulation per point and channel.
// One pixel is in flight at a time.
// The result sits in an output register; the next pixel is accepted while
// it waits, and only a later emission stalls until the receiver takes it.
// Reset clears the state, the configuration registers, the accumulator and the output valid.
module vanishing_point_edge_score_top #(
	parameter int NUM_VANISHING_POINTS = vpes_pkg::NUM_VP_DEF,
	parameter int NUM_CHANNELS         = vpes_pkg::NUM_CH_DEF,
	parameter int COORD_BITS           = vpes_pkg::COORD_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	vpes_pix_if.sink   pix,
	vpes_cfg_if.sink   cfg,
	vpes_res_if.source res
);
	import vpes_pkg::*;

	localparam int NL = (NUM_VANISHING_POINTS < VP_CARRIED) ? NUM_VANISHING_POINTS : VP_CARRIED;
	localparam int NC = (NUM_CHANNELS < CH_CARRIED) ? NUM_CHANNELS : CH_CARRIED;
	localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);

	top_state_t state_q, state_d;
	pix_item_t  item_q;
	logic signed [31:0] vpx_q [VP_CARRIED];
	logic signed [31:0] vpy_q [VP_CARRIED];
	logic signed [31:0] offset_q, slope_q;
	lane_res_t [VP_CARRIED-1:0] dirs;
	logic lane_start, merge_start, merge_done, all_done;
	logic [11:0] px, py;

	assign px = item_q.pixel_x & CMASK;
	assign py = item_q.pixel_y & CMASK;

	for (genvar l = 0; l < VP_CARRIED; l++) begin : g_lane
		if (l < NL) begin : g_on
			vpes_lane u_lane (
				.clk    (clk),
				.arst_n (arst_n),
				.start  (lane_start),
				.vp_x   (vpx_q[l]),
				.vp_y   (vpy_q[l]),
				.px     (px),
				.py     (py),
				.res    (dirs[l])
			);
		end else begin : g_off
			assign dirs[l] = '{done: 1'b1, ux: '0, uy: '0};
		end
	end

	vpes_merge #(.NL(NL), .NC(NC)) u_merge (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (merge_start),
		.dirs        (dirs),
		.item        (item_q),
		.coef_offset (offset_q),
		.coef_slope  (slope_q),
		.done        (merge_done),
		.res         (res)
	);

	always_comb begin
		all_done = 1'b1;
		for (int i = 0; i < VP_CARRIED; i++) all_done = all_done & dirs[i].done;
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			T_IDLE:  if (pix.valid) state_d = T_START;
			T_START: state_d = T_LANES;
			T_LANES: if (all_done) state_d = T_MERGE;
			T_MERGE: if (merge_done) state_d = T_IDLE;
			default: state_d = T_IDLE;
		endcase
	end

	always_comb begin
		pix.ready   = (state_q == T_IDLE);
		cfg.ready   = 1'b1;
		lane_start  = (state_q == T_START);
		merge_start = (state_q == T_LANES) && all_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= T_IDLE;
			offset_q <= '0;
			slope_q  <= '0;
			for (int i = 0; i < VP_CARRIED; i++) begin
				vpx_q[i] <= '0;
				vpy_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg.valid && cfg.ready) begin
				unique case (cfg.data.idx)
					CFG_VP1_X:       vpx_q[0] <= cfg.data.wdata;
					CFG_VP1_Y:       vpy_q[0] <= cfg.data.wdata;
					CFG_VP2_X:       vpx_q[1] <= cfg.data.wdata;
					CFG_VP2_Y:       vpy_q[1] <= cfg.data.wdata;
					CFG_VP3_X:       vpx_q[2] <= cfg.data.wdata;
					CFG_VP3_Y:       vpy_q[2] <= cfg.data.wdata;
					CFG_COEF_OFFSET: offset_q <= cfg.data.wdata;
					CFG_COEF_SLOPE:  slope_q  <= cfg.data.wdata;
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pix.valid && pix.ready) item_q <= pix.data;
	end

`ifndef SYNTHESIS
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(pix.valid && pix.ready) |=> (state_q == T_START))
		else $error("accepted pixel did not start lanes");
	a_merge_after_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		merge_start |-> all_done)
		else $error("merge started before lanes finished");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != T_IDLE) |-> !pix.ready)
		else $error("pixel accepted while busy");
`endif
endmodule
